[hw/rtl/dpfw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the dual-plane framebuffer writer.
// Depends on nothing; every other file of the block imports it.
package dpfw_pkg;

  localparam int PLANE_BYTES_DEF = 4096;
  localparam int IDX_W = 16;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;
  localparam logic [7:0] MSB_MASK   = 8'h80;

  localparam logic [1:0] COL_BLACK = 2'd0;
  localparam logic [1:0] COL_RED   = 2'd1;

  localparam logic [2:0] CFG_LOGICAL_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_LOGICAL_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_PANEL_COLS     = 3'd2;
  localparam logic [2:0] CFG_PANEL_ROWS     = 3'd3;
  localparam logic [2:0] CFG_LANDSCAPE      = 3'd4;

  typedef enum logic [1:0] {
    REQ_PIXEL,
    REQ_RECT,
    REQ_FILL,
    REQ_READ
  } req_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_FILL_LEN,
    ST_RECT_CHK,
    ST_PX_MAP,
    ST_PX_IDX,
    ST_PX_READ,
    ST_PX_WRITE,
    ST_RD,
    ST_RD_OUT
  } state_t;

  typedef logic signed [10:0] coord_t;

  typedef struct packed {
    logic [8:0] logical_width;
    logic [8:0] logical_height;
    logic [7:0] panel_cols;
    logic [8:0] panel_rows;
    logic       landscape;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] nx;
    logic [8:0] ny;
  } pix_map_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] bw;
  } plane_word_t;

  function automatic logic [5:0] row_bytes(input logic [7:0] nw);
    logic [8:0] sum;
    sum = {1'b0, nw} + 9'd7;
    return sum[8:3];
  endfunction

endpackage

[hw/rtl/dpfw_plane_mem.sv]
`timescale 1ns / 1ps
// Synchronous memory holding both planes, one byte pair per word.
// One write port and one read port with registered read data; uses dpfw_pkg.
module dpfw_plane_mem #(
  parameter int DEPTH = dpfw_pkg::PLANE_BYTES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  dpfw_pkg::plane_word_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output dpfw_pkg::plane_word_t rdata
);
  import dpfw_pkg::*;

  plane_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/dpfw_pixel_map.sv]
`timescale 1ns / 1ps
// Clips a drawing coordinate to the logical and native sizes and rotates it
// in landscape mode; uses dpfw_pkg.
module dpfw_pixel_map (
  input  dpfw_pkg::cfg_t     cfg,
  input  dpfw_pkg::coord_t   px,
  input  dpfw_pkg::coord_t   py,
  output dpfw_pkg::pix_map_t map
);
  import dpfw_pkg::*;

  coord_t lw, lh, nw, nh, ny_rot, nx_s, ny_s;
  logic   in_logical, in_native;

  always_comb begin
    lw = $signed({2'b00, cfg.logical_width});
    lh = $signed({2'b00, cfg.logical_height});
    nw = $signed({3'b000, cfg.panel_cols});
    nh = $signed({2'b00, cfg.panel_rows});
    ny_rot = nh - coord_t'(1) - px;
    in_logical = (px >= 0) && (py >= 0) && (px < lw) && (py < lh);
    nx_s = cfg.landscape ? py : px;
    ny_s = cfg.landscape ? ny_rot : py;
    in_native = (nx_s >= 0) && (ny_s >= 0) && (nx_s < nw) && (ny_s < nh);
    map.ok = in_logical && in_native;
    map.nx = nx_s[7:0];
    map.ny = ny_s[8:0];
  end

endmodule

[hw/rtl/dual_plane_framebuffer_writer.sv]
`timescale 1ns / 1ps
// Top level of the dual-plane framebuffer writer: request sequencer around
// the plane memory. Uses dpfw_pkg, dpfw_plane_mem and dpfw_pixel_map.
//
// After reset the block runs a clearing pass that writes white to every byte
// pair, one per cycle, and accepts no request until the pass is done.
// Pixel writes update a plane byte by a read-modify-write through the single
// plane memory, so requests are handled one at a time: a pixel write goes
// through map, index, read and write states, and stops after the map or
// index state when it is clipped; a rectangle is checked and then walks its
// clipped logical area pixel by pixel the same way; a fill computes its
// length and then writes one byte per cycle; a read reads the memory and
// offers its result transaction once the output register is free.
// The output register lets writes proceed while a result still waits.
module dual_plane_framebuffer_writer #(
  parameter int PLANE_BYTES = dpfw_pkg::PLANE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[9:0], pos_y[19:10], rect_w[28:20], rect_h[37:29],
  // pixel_color[39:38], pixel_on[40], read_index[52:41], zeros above.
  input  logic [55:0] s_axis_tdata,
  // req_type[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bw_byte[7:0], red_byte[15:8].
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import dpfw_pkg::*;

  localparam int AW = $clog2(PLANE_BYTES);
  localparam int CW = AW + 1;

  state_t      state, state_next;
  cfg_t        cfg;
  req_t        in_req;
  coord_t      in_x, in_y, in_w, in_h, x_lo_in, y_lo_in, x_sum, y_sum;
  coord_t      x_hi_in, y_hi_in, lw_s, lh_s;
  coord_t      cur_x, cur_y, x_lo, x_hi, y_hi, cur_x_inc, cur_y_inc;
  logic [1:0]  in_color, color;
  logic        in_on, pix_on, rect_mode;
  logic [11:0] in_ridx;
  pix_map_t    map, map_q;
  logic [5:0]  rb;
  logic [14:0] idx_prod, fill_prod;
  logic [IDX_W-1:0] idx;
  logic        idx_in_plane, last_x, done_px, step, load_out, accept;
  logic [AW-1:0] addr, mem_waddr;
  logic [CW-1:0] cnt, fill_len, fill_len_sat;
  plane_word_t fill_word, mem_rdata, mem_wdata, px_word;
  logic        mem_we, mem_re, rd_oor;
  logic [7:0]  mask, out_bw, out_red;
  logic        bw_one, red_one;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {out_red, out_bw};

  assign in_req   = req_t'(s_axis_tuser);
  assign in_x     = {s_axis_tdata[9], s_axis_tdata[9:0]};
  assign in_y     = {s_axis_tdata[19], s_axis_tdata[19:10]};
  assign in_w     = $signed({2'b00, s_axis_tdata[28:20]});
  assign in_h     = $signed({2'b00, s_axis_tdata[37:29]});
  assign in_color = s_axis_tdata[39:38];
  assign in_on    = s_axis_tdata[40];
  assign in_ridx  = s_axis_tdata[52:41];

  assign lw_s    = $signed({2'b00, cfg.logical_width});
  assign lh_s    = $signed({2'b00, cfg.logical_height});
  assign x_lo_in = (in_x < 0) ? coord_t'(0) : in_x;
  assign y_lo_in = (in_y < 0) ? coord_t'(0) : in_y;
  assign x_sum   = in_x + in_w;
  assign y_sum   = in_y + in_h;
  assign x_hi_in = (x_sum > lw_s) ? lw_s : x_sum;
  assign y_hi_in = (y_sum > lh_s) ? lh_s : y_sum;

  assign cur_x_inc = cur_x + coord_t'(1);
  assign cur_y_inc = cur_y + coord_t'(1);
  assign last_x    = (cur_x_inc == x_hi);
  assign done_px   = !rect_mode || (last_x && (cur_y_inc == y_hi));

  assign rb        = row_bytes(cfg.panel_cols);
  assign idx_prod  = 15'(map_q.ny) * 15'(rb);
  assign idx       = {1'b0, idx_prod} + IDX_W'(map_q.nx[7:3]);
  assign idx_in_plane = 32'(idx) < PLANE_BYTES;
  assign fill_prod = 15'(rb) * 15'(cfg.panel_rows);
  assign fill_len_sat = (32'(fill_prod) > PLANE_BYTES) ? CW'(PLANE_BYTES) : CW'(fill_prod);

  assign mask    = MSB_MASK >> map_q.nx[2:0];
  assign bw_one  = !pix_on || (color != COL_BLACK);
  assign red_one = pix_on && (color != COL_BLACK);
  assign px_word.bw  = bw_one ? (mem_rdata.bw | mask) : (mem_rdata.bw & ~mask);
  assign px_word.red = red_one ? (mem_rdata.red | mask) : (mem_rdata.red & ~mask);

  dpfw_pixel_map u_map (
    .cfg (cfg),
    .px  (cur_x),
    .py  (cur_y),
    .map (map)
  );

  dpfw_plane_mem #(
    .DEPTH (PLANE_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = addr;
    mem_wdata = px_word;
    step = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_FILL: begin
        if (cnt == fill_len) begin
          state_next = ST_IDLE;
        end else begin
          mem_we = 1'b1;
          mem_waddr = cnt[AW-1:0];
          mem_wdata = fill_word;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_req)
            REQ_PIXEL: state_next = ST_PX_MAP;
            REQ_RECT:  state_next = ST_RECT_CHK;
            REQ_FILL:  state_next = ST_FILL_LEN;
            REQ_READ:  state_next = ST_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL_LEN: state_next = ST_FILL;
      ST_RECT_CHK: begin
        state_next = ((x_hi > cur_x) && (y_hi > cur_y)) ? ST_PX_MAP : ST_IDLE;
      end
      ST_PX_MAP: begin
        if (map.ok) begin
          state_next = ST_PX_IDX;
        end else begin
          step = 1'b1;
          state_next = done_px ? ST_IDLE : ST_PX_MAP;
        end
      end
      ST_PX_IDX: begin
        if (idx_in_plane) begin
          state_next = ST_PX_READ;
        end else begin
          step = 1'b1;
          state_next = done_px ? ST_IDLE : ST_PX_MAP;
        end
      end
      ST_PX_READ: begin
        mem_re = 1'b1;
        state_next = ST_PX_WRITE;
      end
      ST_PX_WRITE: begin
        mem_we = 1'b1;
        step = 1'b1;
        state_next = done_px ? ST_IDLE : ST_PX_MAP;
      end
      ST_RD: begin
        mem_re = !rd_oor;
        state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.logical_width  <= 9'd250;
      cfg.logical_height <= 9'd122;
      cfg.panel_cols     <= 8'd122;
      cfg.panel_rows     <= 9'd250;
      cfg.landscape      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOGICAL_WIDTH:  cfg.logical_width  <= cfg_data;
        CFG_LOGICAL_HEIGHT: cfg.logical_height <= cfg_data;
        CFG_PANEL_COLS:     cfg.panel_cols     <= cfg_data[7:0];
        CFG_PANEL_ROWS:     cfg.panel_rows     <= cfg_data;
        CFG_LANDSCAPE:      cfg.landscape      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fill_len <= CW'(PLANE_BYTES);
      fill_word <= '{red: BYTE_ZEROS, bw: BYTE_ONES};
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= '0;
      end else if (mem_we && (state == ST_FILL)) begin
        cnt <= cnt + CW'(1);
      end
      if (state == ST_FILL_LEN) begin
        fill_len <= fill_len_sat;
        if (color == COL_BLACK) begin
          fill_word <= '{red: BYTE_ZEROS, bw: BYTE_ZEROS};
        end else if (color == COL_RED) begin
          fill_word <= '{red: BYTE_ONES, bw: BYTE_ONES};
        end else begin
          fill_word <= '{red: BYTE_ZEROS, bw: BYTE_ONES};
        end
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x <= (in_req == REQ_RECT) ? x_lo_in : in_x;
      cur_y <= (in_req == REQ_RECT) ? y_lo_in : in_y;
      x_lo <= x_lo_in;
      x_hi <= x_hi_in;
      y_hi <= y_hi_in;
      rect_mode <= (in_req == REQ_RECT);
      color <= in_color;
      pix_on <= in_on || (in_req == REQ_RECT);
      addr <= AW'(in_ridx);
      rd_oor <= 32'(in_ridx) >= PLANE_BYTES;
    end else if (step) begin
      if (last_x) begin
        cur_x <= x_lo;
        cur_y <= cur_y_inc;
      end else begin
        cur_x <= cur_x_inc;
      end
    end
    if (state == ST_PX_MAP) begin
      map_q <= map;
    end
    if (state == ST_PX_IDX) begin
      addr <= idx[AW-1:0];
    end
    if (load_out) begin
      out_bw  <= rd_oor ? BYTE_ZEROS : mem_rdata.bw;
      out_red <= rd_oor ? BYTE_ZEROS : mem_rdata.red;
    end
  end

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !mem_we)
    else $error("Plane memory written while a new transaction can be accepted.");

  a_fill_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cnt <= fill_len))
    else $error("Fill counter ran past the fill length.");

  a_pixel_addr_in_plane: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PX_WRITE) |-> (32'(addr) < PLANE_BYTES))
    else $error("Pixel write addressed a byte beyond the plane.");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_RD_OUT))
    else $error("Result transaction raised without a completed read.");

endmodule
